// File: src/lsct_pkg.sv
`timescale 1ns / 1ps
// Shared types and timing constants for the LCD scanline/mode timer.
// No dependencies; used by lcd_mode_scanline_timer_top.
package lsct_pkg;

  localparam int ACCUM_W    = 13;
  localparam int COUNT_W    = 6;
  localparam int LINE_W     = 8;
  localparam int STAT_UP_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // mode lengths in machine cycles
  localparam logic [ACCUM_W-1:0] LEN_HBLANK   = ACCUM_W'(204);
  localparam logic [ACCUM_W-1:0] LEN_VBLANK   = ACCUM_W'(4560);
  localparam logic [ACCUM_W-1:0] LEN_OAM      = ACCUM_W'(80);
  localparam logic [ACCUM_W-1:0] LEN_TRANSFER = ACCUM_W'(172);

  localparam int LineLen = 456;
  localparam int ACCUM_MAX = (1 << ACCUM_W) - 1;
  // largest quotient accum / LineLen can reach
  localparam int VBL_Q_MAX = ACCUM_MAX / LineLen;
  localparam int VBL_Q_W   = $clog2(VBL_Q_MAX + 1);

  localparam logic [LINE_W-1:0] LINE_VBL_FIRST   = LINE_W'(144);
  localparam logic [LINE_W-1:0] LINE_LAST_ACTIVE = LINE_W'(143);

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_OAM      = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LCD_ENABLE   = 2'd0,
    REG_STAT_UPPER   = 2'd1,
    REG_LINE_COMPARE = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  function automatic logic [ACCUM_W-1:0] mode_len(input mode_t m);
    logic [ACCUM_W-1:0] len;
    unique case (m)
      MODE_HBLANK:   len = LEN_HBLANK;
      MODE_VBLANK:   len = LEN_VBLANK;
      MODE_OAM:      len = LEN_OAM;
      MODE_TRANSFER: len = LEN_TRANSFER;
      default:       len = LEN_OAM;
    endcase
    return len;
  endfunction

endpackage

// File: src/lcd_mode_scanline_timer_top.sv
`timescale 1ns / 1ps
// LCD scanline/mode timer: cycle accumulator, mode sequencer, STAT/vblank requests.
// Depends on lsct_pkg.
//
// Usage:
//  - Item channel (item_valid/item_stall): one beat carries cycle_count, the
//    machine cycles elapsed since the previous beat.
//  - Result channel (result_valid/result_stall): one beat per item with
//    scan_line, lcd_mode, status_byte, stat_irq, vblank_irq, frame_ready.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//    lcd_enable, 1 stat_upper, 2 line_compare; cfg_ready is always high.
//    Write only while no result is outstanding.
//  - Latency: a result is valid the cycle after its item is accepted.
//  - Throughput: one item per clock while item_stall is low; the timer state and
//    the result register both update in the accepting cycle.
//  - item_stall is high only while the result register is full and the
//    receiver stalls it; the held result does not change meanwhile.
//  - Reset (rst, synchronous): line 0, mode 2, accumulator 0, display enabled,
//    stat_upper and line_compare cleared, result register empty.
module lcd_mode_scanline_timer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [lsct_pkg::COUNT_W-1:0]     cycle_count,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [lsct_pkg::LINE_W-1:0]      scan_line,
  output logic [1:0]                       lcd_mode,
  output logic [7:0]                       status_byte,
  output logic                             stat_irq,
  output logic                             vblank_irq,
  output logic                             frame_ready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = lsct_pkg::ACCUM_W;
  localparam int LW = lsct_pkg::LINE_W;
  localparam int QN = lsct_pkg::VBL_Q_MAX;
  localparam int QW = lsct_pkg::VBL_Q_W;

  // config registers
  logic                              lcd_enable;
  logic [lsct_pkg::STAT_UP_W-1:0]    stat_upper;
  logic [LW-1:0]                     line_compare;

  // timer state
  logic [AW-1:0]        accum, accum_next;
  lsct_pkg::mode_t      mode, mode_next;
  logic [LW-1:0]        line, line_next;

  logic                 item_fire;
  logic [AW-1:0]        accum_sum;
  logic [AW-1:0]        len;
  logic [QN-1:0]        vbl_thermo;
  logic [QW-1:0]        vbl_q;
  logic [LW-1:0]        line_mid;
  logic                 stat_req, vbl_req, frame;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid & result_stall;
  assign item_fire  = item_valid & ~item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_enable   <= 1'b1;
      stat_upper   <= '0;
      line_compare <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lsct_pkg::cfg_reg_t'(cfg_index))
        lsct_pkg::REG_LCD_ENABLE:   lcd_enable   <= cfg_data[0];
        lsct_pkg::REG_STAT_UPPER:   stat_upper   <= cfg_data[lsct_pkg::STAT_UP_W-1:0];
        lsct_pkg::REG_LINE_COMPARE: line_compare <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // vblank line offset from 144 = accum_sum / 456, as a count of passed line thresholds
  always_comb begin
    for (int k = 0; k < QN; k++) begin
      vbl_thermo[k] = (accum_sum >= AW'((k + 1) * lsct_pkg::LineLen));
    end
    vbl_q = QW'($countones(vbl_thermo));
  end

  always_comb begin
    accum_sum  = AW'(accum + AW'(cycle_count));
    len        = lsct_pkg::mode_len(mode);
    accum_next = accum;
    mode_next  = mode;
    line_next  = line;
    line_mid   = line;
    stat_req   = 1'b0;
    vbl_req    = 1'b0;
    frame      = 1'b0;

    if (lcd_enable) begin
      // STAT select priority: LYC, then mode 2, mode 1, mode 0 (pre-step values)
      if (stat_upper[3])      stat_req = (line == line_compare);
      else if (stat_upper[2]) stat_req = (mode == lsct_pkg::MODE_OAM);
      else if (stat_upper[1]) stat_req = (mode == lsct_pkg::MODE_VBLANK);
      else if (stat_upper[0]) stat_req = (mode == lsct_pkg::MODE_HBLANK);

      if (mode == lsct_pkg::MODE_VBLANK) begin
        line_mid = LW'(lsct_pkg::LINE_VBL_FIRST + LW'(vbl_q));
      end

      accum_next = accum_sum;
      line_next  = line_mid;
      if (accum_sum >= len) begin
        accum_next = AW'(accum_sum - len);
        unique case (mode)
          lsct_pkg::MODE_OAM:      mode_next = lsct_pkg::MODE_TRANSFER;
          lsct_pkg::MODE_TRANSFER: mode_next = lsct_pkg::MODE_HBLANK;
          lsct_pkg::MODE_HBLANK: begin
            if (line_mid == lsct_pkg::LINE_LAST_ACTIVE) begin
              mode_next = lsct_pkg::MODE_VBLANK;
              vbl_req   = 1'b1;
            end else begin
              mode_next = lsct_pkg::MODE_OAM;
              line_next = LW'(line_mid + LW'(1));
            end
          end
          default: begin
            mode_next = lsct_pkg::MODE_OAM;
            line_next = '0;
            frame     = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum        <= '0;
      mode         <= lsct_pkg::MODE_OAM;
      line         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_fire) begin
        accum        <= accum_next;
        mode         <= mode_next;
        line         <= line_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (item_fire) begin
      scan_line   <= line_next;
      lcd_mode    <= mode_next;
      status_byte <= {stat_upper, (line_next == line_compare), mode_next};
      stat_irq    <= stat_req;
      vblank_irq  <= vbl_req;
      frame_ready <= frame;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item_stall raised with empty result register");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    (result_valid && vblank_irq) |-> (lcd_mode == lsct_pkg::MODE_VBLANK &&
                                      scan_line == lsct_pkg::LINE_LAST_ACTIVE))
    else $error("vblank request without entering mode 1 at last active line");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_ready) |-> (lcd_mode == lsct_pkg::MODE_OAM && scan_line == '0))
    else $error("frame_ready without restart at line 0");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (item_fire && !lcd_enable) |=> (!stat_irq && !vblank_irq && !frame_ready &&
                                    $stable(mode) && $stable(line)))
    else $error("timer advanced while display disabled");
`endif

endmodule
